// File: src/fpa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU.
// Used by fpa_div and fixed_point_q24_8_alu; no dependencies.
package fpa_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [3:0] {
        FUNC_ADD      = 4'd0,
        FUNC_SUB      = 4'd1,
        FUNC_MUL      = 4'd2,
        FUNC_DIV      = 4'd3,
        FUNC_GT       = 4'd4,
        FUNC_LT       = 4'd5,
        FUNC_GE       = 4'd6,
        FUNC_LE       = 4'd7,
        FUNC_EQ       = 4'd8,
        FUNC_NE       = 4'd9,
        FUNC_MIN      = 4'd10,
        FUNC_MAX      = 4'd11,
        FUNC_INC      = 4'd12,
        FUNC_DEC      = 4'd13,
        FUNC_FROM_INT = 4'd14,
        FUNC_TO_INT   = 4'd15
    } t_func;

    // Per-beat data that rides alongside the divider stages.
    typedef struct packed {
        logic [DATA_W-1:0] res;     // final result for every non-divide op
        logic              cmp;
        logic              dz;
        logic              is_div;
        logic              neg;     // quotient sign
    } t_side;

endpackage

// File: src/fpa_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on fpa_pkg (DATA_W, t_side).
module fpa_div #(
    parameter int DVD_W = 40
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [DVD_W-1:0]         i_dividend,
    input  logic [fpa_pkg::DATA_W-1:0] i_divisor,
    input  fpa_pkg::t_side           i_side,
    output logic                     o_valid,
    output logic [DVD_W-1:0]         o_quotient,
    output fpa_pkg::t_side           o_side
);

    localparam int DW = fpa_pkg::DATA_W;

    // dq holds the dividend bits not yet consumed (top) and quotient bits (bottom)
    logic [DW-1:0]    r_rem  [DVD_W];
    logic [DVD_W-1:0] r_dq   [DVD_W];
    logic [DW-1:0]    r_den  [DVD_W];
    logic             r_vld  [DVD_W];
    fpa_pkg::t_side   r_side [DVD_W];

    for (genvar k = 0; k < DVD_W; k++) begin : g_stage
        logic [DW-1:0]    w_rem;
        logic [DVD_W-1:0] w_dq;
        logic [DW-1:0]    w_den;
        logic             w_vld;
        fpa_pkg::t_side   w_side;
        logic [DW:0]      w_trial;
        logic [DW:0]      w_diff;
        logic             w_ge;
        logic [DW-1:0]    n_rem;
        logic [DVD_W-1:0] n_dq;

        if (k == 0) begin : g_first
            assign w_rem  = '0;
            assign w_dq   = i_dividend;
            assign w_den  = i_divisor;
            assign w_vld  = i_valid;
            assign w_side = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_dq   = r_dq[k-1];
            assign w_den  = r_den[k-1];
            assign w_vld  = r_vld[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_trial = {w_rem, w_dq[DVD_W-1]};
        assign w_diff  = w_trial - {1'b0, w_den};
        assign w_ge    = ~w_diff[DW];
        assign n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        assign n_dq    = {w_dq[DVD_W-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld;
            end
            r_rem[k]  <= n_rem;
            r_dq[k]   <= n_dq;
            r_den[k]  <= w_den;
            r_side[k] <= w_side;
        end
    end

    assign o_valid    = r_vld[DVD_W-1];
    assign o_quotient = r_dq[DVD_W-1];
    assign o_side     = r_side[DVD_W-1];

endmodule

// File: src/fixed_point_q24_8_alu.sv
// Top level of the Q24.8 fixed-point ALU: input stages, multiplier, divider, output.
// Depends on fpa_pkg and fpa_div.
//
// Usage:
//   Drive i_func, i_operand_a and i_operand_b with i_start high; the beat is
//   taken at any edge where i_start is high and o_busy is low. o_busy is
//   always low: the pipeline takes a new beat every cycle.
//   Each result appears on o_result, o_compare_true and o_divide_by_zero for
//   exactly one cycle with o_done high, in the order the beats were taken.
//   Every beat passes through the same registers, whatever its opcode.
//   The depth is set by the divider, which resolves one quotient bit per
//   stage over 32 + FRAC_BITS stages; three stages in front (input,
//   multiplier, product scaling) and one output register complete it.
//   Throughput: one beat per cycle, for any mix of opcodes.
//   Reset (synchronous, active low) clears all valid bits; beats in flight
//   are dropped. The receiver cannot stall, so no back-pressure exists.
//   Divide by zero returns 0 with o_divide_by_zero set.
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [3:0]         i_func,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_busy,
    output logic               o_done,
    output logic signed [31:0] o_result,
    output logic               o_compare_true,
    output logic               o_divide_by_zero
);

    localparam int DW    = fpa_pkg::DATA_W;
    localparam int DVD_W = DW + FRAC_BITS;
    localparam int LAT   = DVD_W + 4;
    localparam logic [2*DW-1:0] MUL_BIAS = {{(2*DW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    // ---------------- stage 1: input register
    logic               r_s1_vld;
    fpa_pkg::t_func     r_s1_func;
    logic signed [DW-1:0] r_s1_a;
    logic signed [DW-1:0] r_s1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start && !o_busy;
        end
        r_s1_func <= fpa_pkg::t_func'(i_func);
        r_s1_a    <= i_operand_a;
        r_s1_b    <= i_operand_b;
    end

    // ---------------- stage 2: product, simple ops, divider operand prep
    logic signed [2*DW-1:0] w_a64;
    logic signed [2*DW-1:0] w_b64;
    logic signed [2*DW-1:0] n_s2_prod;
    logic [DW-1:0]          n_s2_res;
    logic                   n_s2_cmp;
    logic                   n_s2_dz;
    logic                   n_s2_is_div;
    logic                   w_is_cmp;
    logic [DW-1:0]          n_s2_abs_a;
    logic [DW-1:0]          n_s2_abs_b;
    logic                   n_s2_neg;

    assign w_a64      = {{DW{r_s1_a[DW-1]}}, r_s1_a};
    assign w_b64      = {{DW{r_s1_b[DW-1]}}, r_s1_b};
    assign n_s2_prod  = w_a64 * w_b64;
    assign n_s2_abs_a = r_s1_a[DW-1] ? (~r_s1_a + 1'b1) : r_s1_a;
    assign n_s2_abs_b = r_s1_b[DW-1] ? (~r_s1_b + 1'b1) : r_s1_b;
    assign n_s2_neg   = r_s1_a[DW-1] ^ r_s1_b[DW-1];

    always_comb begin
        n_s2_res    = '0;
        n_s2_cmp    = 1'b0;
        n_s2_dz     = 1'b0;
        n_s2_is_div = 1'b0;
        w_is_cmp    = 1'b0;
        case (r_s1_func)
            fpa_pkg::FUNC_ADD:      n_s2_res = r_s1_a + r_s1_b;
            fpa_pkg::FUNC_SUB:      n_s2_res = r_s1_a - r_s1_b;
            fpa_pkg::FUNC_MUL:      n_s2_res = '0;  // filled in stage 3
            fpa_pkg::FUNC_DIV: begin
                n_s2_is_div = 1'b1;
                n_s2_dz     = (r_s1_b == '0);
            end
            fpa_pkg::FUNC_GT: begin w_is_cmp = 1'b1; n_s2_cmp = r_s1_a >  r_s1_b; end
            fpa_pkg::FUNC_LT: begin w_is_cmp = 1'b1; n_s2_cmp = r_s1_a <  r_s1_b; end
            fpa_pkg::FUNC_GE: begin w_is_cmp = 1'b1; n_s2_cmp = r_s1_a >= r_s1_b; end
            fpa_pkg::FUNC_LE: begin w_is_cmp = 1'b1; n_s2_cmp = r_s1_a <= r_s1_b; end
            fpa_pkg::FUNC_EQ: begin w_is_cmp = 1'b1; n_s2_cmp = r_s1_a == r_s1_b; end
            fpa_pkg::FUNC_NE: begin w_is_cmp = 1'b1; n_s2_cmp = r_s1_a != r_s1_b; end
            // ties return operand_b
            fpa_pkg::FUNC_MIN:      n_s2_res = (r_s1_a < r_s1_b) ? r_s1_a : r_s1_b;
            fpa_pkg::FUNC_MAX:      n_s2_res = (r_s1_a > r_s1_b) ? r_s1_a : r_s1_b;
            fpa_pkg::FUNC_INC:      n_s2_res = r_s1_a + 1'b1;
            fpa_pkg::FUNC_DEC:      n_s2_res = r_s1_a - 1'b1;
            fpa_pkg::FUNC_FROM_INT: n_s2_res = r_s1_a << FRAC_BITS;
            fpa_pkg::FUNC_TO_INT:   n_s2_res = r_s1_a >>> FRAC_BITS;
            default:                n_s2_res = '0;
        endcase
        if (w_is_cmp) begin
            n_s2_res = {{(DW-1){1'b0}}, n_s2_cmp};
        end
    end

    logic                   r_s2_vld;
    logic                   r_s2_is_mul;
    logic signed [2*DW-1:0] r_s2_prod;
    logic [DW-1:0]          r_s2_res;
    logic                   r_s2_cmp;
    logic                   r_s2_dz;
    logic                   r_s2_is_div;
    logic [DW-1:0]          r_s2_abs_a;
    logic [DW-1:0]          r_s2_abs_b;
    logic                   r_s2_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_is_mul <= (r_s1_func == fpa_pkg::FUNC_MUL);
        r_s2_prod   <= n_s2_prod;
        r_s2_res    <= n_s2_res;
        r_s2_cmp    <= n_s2_cmp;
        r_s2_dz     <= n_s2_dz;
        r_s2_is_div <= n_s2_is_div;
        r_s2_abs_a  <= n_s2_abs_a;
        r_s2_abs_b  <= n_s2_abs_b;
        r_s2_neg    <= n_s2_neg;
    end

    // ---------------- stage 3: scale product toward zero, build divider inputs
    logic [2*DW-1:0]  w_biased;
    fpa_pkg::t_side   n_s3_side;

    assign w_biased = r_s2_prod + (r_s2_prod[2*DW-1] ? MUL_BIAS : '0);

    always_comb begin
        n_s3_side.res    = r_s2_is_mul ? w_biased[FRAC_BITS+DW-1:FRAC_BITS] : r_s2_res;
        n_s3_side.cmp    = r_s2_cmp;
        n_s3_side.dz     = r_s2_dz;
        n_s3_side.is_div = r_s2_is_div;
        n_s3_side.neg    = r_s2_neg;
    end

    logic              r_s3_vld;
    fpa_pkg::t_side    r_s3_side;
    logic [DVD_W-1:0]  r_s3_dvd;
    logic [DW-1:0]     r_s3_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
        r_s3_side <= n_s3_side;
        r_s3_dvd  <= {r_s2_abs_a, {FRAC_BITS{1'b0}}};
        r_s3_dvs  <= r_s2_abs_b;
    end

    // ---------------- divider stages
    logic              w_div_vld;
    logic [DVD_W-1:0]  w_div_quot;
    fpa_pkg::t_side    w_div_side;

    fpa_div #(
        .DVD_W (DVD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s3_vld),
        .i_dividend (r_s3_dvd),
        .i_divisor  (r_s3_dvs),
        .i_side     (r_s3_side),
        .o_valid    (w_div_vld),
        .o_quotient (w_div_quot),
        .o_side     (w_div_side)
    );

    // ---------------- output register
    logic [DW-1:0] w_q32;
    logic [DW-1:0] n_out_res;
    logic          r_out_vld;
    logic [DW-1:0] r_out_res;
    logic          r_out_cmp;
    logic          r_out_dz;

    // quotient wraps to 32 bits; sign applied on the low word
    assign w_q32 = w_div_quot[DW-1:0];

    always_comb begin
        if (!w_div_side.is_div) begin
            n_out_res = w_div_side.res;
        end else if (w_div_side.dz) begin
            n_out_res = '0;
        end else begin
            n_out_res = w_div_side.neg ? (~w_q32 + 1'b1) : w_q32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_div_vld;
        end
        r_out_res <= n_out_res;
        r_out_cmp <= w_div_side.cmp;
        r_out_dz  <= w_div_side.dz;
    end

    assign o_busy           = 1'b0;
    assign o_done           = r_out_vld;
    assign o_result         = r_out_res;
    assign o_compare_true   = r_out_cmp;
    assign o_divide_by_zero = r_out_dz;

    // ---------------- assertions
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_done)
        else $error("result missing at fixed latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, LAT))
        else $error("result without a matching input beat");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_divide_by_zero) |-> (o_result == '0 && !o_compare_true))
        else $error("divide by zero with nonzero result");

    a_cmp_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_compare_true) |-> (o_result == 32'sd1 && !o_divide_by_zero))
        else $error("compare true without result of one");

endmodule
